// File: rtl/lds_pkg.sv
package lds_pkg;

    // Field and register widths.
    localparam int DICE_W = 4;
    localparam int SIDE_W = 7;
    localparam int SEED_W = 10;
    localparam int SUM_W  = 11;

    // Register reset values.
    localparam logic [DICE_W-1:0] DICE_RESET = 4'd3;
    localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd6;
    localparam logic [SEED_W-1:0] SEED_RESET = 10'd427;

    // Register map, indexed by paddr[3:2].
    localparam int PADDR_W = 4;
    typedef enum logic [1:0] {
        REG_DICE_COUNT = 2'd0,
        REG_SIDE_COUNT = 2'd1,
        REG_START_SEED = 2'd2,
        REG_UNUSED     = 2'd3
    } lds_reg_e;

    // Generator step: seed = (40*seed + 3641) mod 729.
    localparam int LCG_T_W = 16;
    localparam logic [LCG_T_W-1:0] LCG_MUL = 16'd40;
    localparam logic [LCG_T_W-1:0] LCG_ADD = 16'd3641;
    localparam logic [10:0]        LCG_MOD = 11'd729;
    // Quotient estimate floor(t * 2^26 / 729) / 2^26 is exact or one low.
    localparam logic [16:0] LCG_RECIP = 17'd92056;
    localparam int LCG_SHIFT = 26;
    localparam int LCG_Q_W   = 6;

    // Remainder unit processes one dividend bit per cycle.
    localparam int DIV_CNT_W = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_BITS = 4'd10;

    // Microprogram.
    localparam int UPC_W = 4;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_LCG_A,
        OP_LCG_B,
        OP_LCG_C,
        OP_LCG_D,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_ACC,
        OP_EMIT
    } lds_op_e;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_DICE_ZERO,
        C_DIV_MORE,
        C_OUT_FULL
    } lds_cond_e;

    typedef struct packed {
        logic             in_ready;
        lds_op_e          op;
        lds_cond_e        hold;
        lds_cond_e        jmp;
        logic [UPC_W-1:0] target;
    } lds_uword_t;

    // Control word as issued to the datapath.
    typedef struct packed {
        logic    in_ready;
        lds_op_e op;
    } lds_ctl_t;

    // Status flags tested by the sequencer.
    typedef struct packed {
        logic no_input;
        logic dice_zero;
        logic div_more;
        logic out_full;
    } lds_stat_t;

    localparam logic [UPC_W-1:0] STEP_WAIT  = 4'd0;
    localparam logic [UPC_W-1:0] STEP_CHECK = 4'd1;
    localparam logic [UPC_W-1:0] STEP_LCG_A = 4'd2;
    localparam logic [UPC_W-1:0] STEP_LCG_B = 4'd3;
    localparam logic [UPC_W-1:0] STEP_LCG_C = 4'd4;
    localparam logic [UPC_W-1:0] STEP_LCG_D = 4'd5;
    localparam logic [UPC_W-1:0] STEP_DLOAD = 4'd6;
    localparam logic [UPC_W-1:0] STEP_DSTEP = 4'd7;
    localparam logic [UPC_W-1:0] STEP_ACC   = 4'd8;
    localparam logic [UPC_W-1:0] STEP_EMIT  = 4'd9;

    function automatic lds_uword_t lds_rom(input logic [UPC_W-1:0] addr);
        lds_uword_t w;
        w = '{in_ready: 1'b0, op: OP_NONE, hold: C_NEVER, jmp: C_NEVER, target: STEP_WAIT};
        case (addr)
            STEP_WAIT:
            begin
                w.in_ready = 1'b1;
                w.op       = OP_START;
                w.hold     = C_NO_INPUT;
            end
            STEP_CHECK:
            begin
                w.jmp    = C_DICE_ZERO;
                w.target = STEP_EMIT;
            end
            STEP_LCG_A: w.op = OP_LCG_A;
            STEP_LCG_B: w.op = OP_LCG_B;
            STEP_LCG_C: w.op = OP_LCG_C;
            STEP_LCG_D: w.op = OP_LCG_D;
            STEP_DLOAD: w.op = OP_DIV_LOAD;
            STEP_DSTEP:
            begin
                w.op   = OP_DIV_STEP;
                w.hold = C_DIV_MORE;
            end
            STEP_ACC:
            begin
                w.op     = OP_ACC;
                w.jmp    = C_ALWAYS;
                w.target = STEP_CHECK;
            end
            STEP_EMIT:
            begin
                w.op     = OP_EMIT;
                w.hold   = C_OUT_FULL;
                w.jmp    = C_ALWAYS;
                w.target = STEP_WAIT;
            end
            default:
            begin
                w.jmp    = C_ALWAYS;
                w.target = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

// File: rtl/lds_ifs.sv
interface lds_req_if;
    logic valid;
    logic ready;
    logic reseed;

    modport source (output valid, output reseed, input ready);
    modport sink (input valid, input reseed, output ready);
endinterface

interface lds_rsp_if;
    logic        valid;
    logic        ready;
    logic [10:0] dice_sum;

    modport source (output valid, output dice_sum, input ready);
    modport sink (input valid, input dice_sum, output ready);
endinterface

// File: rtl/lcg_dice_sum_roller.sv
// Channel  Dir  Payload              Transfer
// req      in   reseed (1 bit)       req.valid && req.ready
// rsp      out  dice_sum (11 bits)   rsp.valid && rsp.ready
// apb      in   dice/side/seed regs  psel && penable && pwrite (pready tied high)
//
// A request is taken in the wait step, and the next request can be taken in the
// cycle after the result register is loaded. Each die runs the die count test,
// the generator steps LCG_A to LCG_D with modulo-729 reduction, a load, a remainder
// step by side_count for each of the ten seed bits and the add, all run by the microprogram.
// Reset clears the step counter, die counter, divider bit counter, generator seed and output valid.
// A new request is taken while a result waits; the next result stalls in
// the final step until the output register is free.
module lcg_dice_sum_roller
    import lds_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    lds_req_if.sink            req,
    lds_rsp_if.source          rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    lds_ctl_t  ctl;
    lds_stat_t stat;

    logic [DICE_W-1:0] dice_count_reg;
    logic [SIDE_W-1:0] side_count_reg;
    logic [SEED_W-1:0] start_seed_reg;
    logic [DICE_W-1:0] die_cnt_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  dice_sum_reg;
    logic              out_valid_reg;
    logic              cfg_write;
    lds_reg_e          reg_sel;
    logic [SEED_W-1:0] seed;
    logic [SIDE_W-1:0] remainder;
    logic              div_more;
    logic [SIDE_W-1:0] die_rem;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_sel   = lds_reg_e'(paddr[3:2]);

    always_comb
    begin
        case (reg_sel)
            REG_DICE_COUNT: prdata = 32'(dice_count_reg);
            REG_SIDE_COUNT: prdata = 32'(side_count_reg);
            REG_START_SEED: prdata = 32'(start_seed_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dice_count_reg <= DICE_RESET;
            side_count_reg <= SIDE_RESET;
            start_seed_reg <= SEED_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_DICE_COUNT: dice_count_reg <= pwdata[DICE_W-1:0];
                REG_SIDE_COUNT: side_count_reg <= pwdata[SIDE_W-1:0];
                REG_START_SEED: start_seed_reg <= pwdata[SEED_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign req.ready     = ctl.in_ready;
    assign rsp.valid     = out_valid_reg;
    assign rsp.dice_sum  = dice_sum_reg;

    assign stat.no_input  = !req.valid;
    assign stat.dice_zero = (die_cnt_reg == '0);
    assign stat.div_more  = div_more;
    assign stat.out_full  = out_valid_reg && !rsp.ready;

    // With zero sides every die shows one.
    assign die_rem = (side_count_reg == '0) ? '0 : remainder;

    lds_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    lds_lcg u_lcg (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .reseed     (req.reseed),
        .start_seed (start_seed_reg),
        .seed       (seed)
    );

    lds_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .dividend  (seed),
        .divisor   (side_count_reg),
        .remainder (remainder),
        .more      (div_more)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            die_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.op == OP_START)
            begin
                die_cnt_reg <= dice_count_reg;
            end
            else if (ctl.op == OP_ACC)
            begin
                die_cnt_reg <= die_cnt_reg - 1'b1;
            end

            if (ctl.op == OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctl.op)
            OP_START: sum_reg      <= '0;
            OP_ACC:   sum_reg      <= sum_reg + SUM_W'(die_rem) + SUM_W'(1);
            OP_EMIT:  dice_sum_reg <= sum_reg;
            default:
            begin
            end
        endcase
    end

endmodule

// File: rtl/lds_sequencer.sv
module lds_sequencer
    import lds_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  lds_stat_t stat,
    output lds_ctl_t  ctl
);

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    lds_uword_t       uword;
    logic             hold_true;
    logic             jmp_true;

    function automatic logic cond_eval(input lds_cond_e c, input lds_stat_t s);
        logic r;
        case (c)
            C_NEVER:     r = 1'b0;
            C_ALWAYS:    r = 1'b1;
            C_NO_INPUT:  r = s.no_input;
            C_DICE_ZERO: r = s.dice_zero;
            C_DIV_MORE:  r = s.div_more;
            C_OUT_FULL:  r = s.out_full;
            default:     r = 1'b0;
        endcase
        return r;
    endfunction

    assign uword     = lds_rom(upc_reg);
    assign hold_true = cond_eval(uword.hold, stat);
    assign jmp_true  = cond_eval(uword.jmp, stat);

    always_comb
    begin
        if (hold_true)
        begin
            upc_next = upc_reg;
        end
        else if (jmp_true)
        begin
            upc_next = uword.target;
        end
        else
        begin
            upc_next = upc_reg + 1'b1;
        end
    end

    // A held step does nothing, except the divide step, which iterates in place.
    always_comb
    begin
        ctl.in_ready = uword.in_ready;
        if (hold_true && (uword.op != OP_DIV_STEP))
        begin
            ctl.op = OP_NONE;
        end
        else
        begin
            ctl.op = uword.op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= STEP_WAIT;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

// File: rtl/lds_lcg.sv
module lds_lcg
    import lds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  lds_ctl_t          ctl,
    input  logic              reseed,
    input  logic [SEED_W-1:0] start_seed,
    output logic [SEED_W-1:0] seed
);

    logic [SEED_W-1:0]  seed_reg;
    logic [LCG_T_W-1:0] t_reg;
    logic [LCG_Q_W-1:0] q_reg;
    logic [10:0]        r_reg;
    logic [31:0]        prod;
    logic [LCG_T_W-1:0] qm;

    assign prod = 32'(t_reg) * 32'(LCG_RECIP);
    assign qm   = LCG_T_W'(q_reg) * LCG_T_W'(LCG_MOD);
    assign seed = seed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else
        begin
            case (ctl.op)
                OP_START:
                begin
                    if (reseed)
                    begin
                        seed_reg <= start_seed;
                    end
                end
                OP_LCG_D:
                begin
                    if (r_reg >= LCG_MOD)
                    begin
                        seed_reg <= SEED_W'(r_reg - LCG_MOD);
                    end
                    else
                    begin
                        seed_reg <= SEED_W'(r_reg);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Reduction pipeline: t = 40*seed + 3641, quotient estimate, remainder below 2*729.
    always_ff @(posedge clk)
    begin
        case (ctl.op)
            OP_LCG_A: t_reg <= LCG_T_W'(seed_reg) * LCG_MUL + LCG_ADD;
            OP_LCG_B: q_reg <= prod[LCG_SHIFT +: LCG_Q_W];
            OP_LCG_C: r_reg <= 11'(t_reg - qm);
            default:
            begin
            end
        endcase
    end

endmodule

// File: rtl/lds_divider.sv
module lds_divider
    import lds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  lds_ctl_t          ctl,
    input  logic [SEED_W-1:0] dividend,
    input  logic [SIDE_W-1:0] divisor,
    output logic [SIDE_W-1:0] remainder,
    output logic              more
);

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SEED_W-1:0]    dvd_reg;
    logic [SIDE_W-1:0]    rem_reg;
    logic [SIDE_W:0]      trial;

    assign trial     = {rem_reg, dvd_reg[SEED_W-1]};
    assign remainder = rem_reg;
    assign more      = (cnt_reg != DIV_CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.op == OP_DIV_LOAD)
        begin
            cnt_reg <= DIV_BITS;
        end
        else if (ctl.op == OP_DIV_STEP)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Restoring remainder, one dividend bit per cycle, most significant first.
    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_DIV_LOAD)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (ctl.op == OP_DIV_STEP)
        begin
            dvd_reg <= {dvd_reg[SEED_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                rem_reg <= SIDE_W'(trial - {1'b0, divisor});
            end
            else
            begin
                rem_reg <= SIDE_W'(trial);
            end
        end
    end

endmodule

// File: bench/lds_checker.sv
module lds_checker
    import lds_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    lds_req_if                 req_mon,
    lds_rsp_if                 rsp_mon,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output int                 fail_count,
    output int                 pending
);

    logic [DICE_W-1:0] dice_cfg;
    logic [SIDE_W-1:0] side_cfg;
    logic [SEED_W-1:0] seed_cfg;
    logic [SEED_W-1:0] roll_seed;
    logic [SUM_W-1:0]  expected_sums[$];
    logic [SUM_W-1:0]  want_sum;
    logic [SUM_W-1:0]  roll_total;
    logic [SEED_W-1:0] next_seed;

    function automatic logic [SEED_W-1:0] lcg_advance(input logic [SEED_W-1:0] s);
        int t;
        t = 40 * int'(s) + 3641;
        return SEED_W'(t % 729);
    endfunction

    // Rolls every configured die from the given seed, or from the start seed on a reseed, and returns the new seed.
    function automatic void roll_request(input logic reseed, input logic [SEED_W-1:0] seed_in,
                                         output logic [SUM_W-1:0] sum_out,
                                         output logic [SEED_W-1:0] seed_out);
        logic [SEED_W-1:0] s;
        int                total;
        s = reseed ? seed_cfg : seed_in;
        total = 0;
        for (int k = 0; k < int'(dice_cfg); k++)
        begin
            s = lcg_advance(s);
            // With no sides configured every die shows one.
            total += 1 + ((side_cfg != '0) ? (int'(s) % int'(side_cfg)) : 0);
        end
        sum_out  = SUM_W'(total);
        seed_out = s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dice_cfg   <= DICE_RESET;
            side_cfg   <= SIDE_RESET;
            seed_cfg   <= SEED_RESET;
            roll_seed  <= '0;
            fail_count <= 0;
            pending    <= 0;
            expected_sums.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (lds_reg_e'(paddr[3:2]))
                    REG_DICE_COUNT: dice_cfg <= pwdata[DICE_W-1:0];
                    REG_SIDE_COUNT: side_cfg <= pwdata[SIDE_W-1:0];
                    REG_START_SEED: seed_cfg <= pwdata[SEED_W-1:0];
                    default: ;
                endcase
            end
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                if (expected_sums.size() == 0)
                begin
                    $error("dice_sum: unexpected result %0d", rsp_mon.dice_sum);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want_sum = expected_sums.pop_front();
                    if (rsp_mon.dice_sum !== want_sum)
                    begin
                        $error("dice_sum mismatch: expected %0d, actual %0d",
                               want_sum, rsp_mon.dice_sum);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (req_mon.valid && req_mon.ready)
            begin
                roll_request(req_mon.reseed, roll_seed, roll_total, next_seed);
                roll_seed <= next_seed;
                expected_sums.push_back(roll_total);
            end
            pending <= expected_sums.size();
        end
    end

endmodule

// File: bench/tb_top.sv
module tb_top;
    import lds_pkg::*;

    localparam int IDLE_LIMIT  = 5000;
    localparam int HOLD_CYCLES = 600;
    localparam int TAIL_CYCLES = 300;
    localparam int RANDOM_ITEMS = 1150;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles;
    int                 rolled;
    int                 phase;
    bit                 steady_req;

    lds_req_if req_if();
    lds_rsp_if rsp_if();

    lcg_dice_sum_roller dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .rsp     (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    lds_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_mon    (req_if),
        .rsp_mon    (rsp_if),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic apb_write(input lds_reg_e r, input logic [SEED_W-1:0] field);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        // Bits above the register width are junk that the block must drop.
        pwdata  <= {22'($urandom_range(0, 4194303)), field};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_req(input logic rs);
        int gap;
        gap = steady_req ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid  <= 1'b1;
        req_if.reseed <= rs;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
    endtask

    // Stop offering and let every outstanding roll come back.
    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic set_dice(input int dice, input int sides, input int seed);
        drain();
        apb_write(REG_DICE_COUNT, SEED_W'(dice));
        apb_write(REG_SIDE_COUNT, SEED_W'(sides));
        apb_write(REG_START_SEED, SEED_W'(seed));
    endtask

    task automatic send_random(input int n, input int reseed_pct);
        for (int i = 0; i < n; i++)
        begin
            send_req($urandom_range(99) < reseed_pct);
            rolled++;
        end
    endtask

    // Receiver side: random stalls, free-running stretches, and one long hold
    // once the third random phase has started.
    initial
    begin
        int g;
        bit held;
        held = 1'b0;
        rsp_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (phase >= 2 && !held)
            begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                held = 1'b1;
            end
            else if ($urandom_range(9) == 0)
            begin
                rsp_if.ready <= 1'b1;
                repeat ($urandom_range(50, 200)) @(posedge clk);
            end
            else
            begin
                g = pick_gap();
                if (g > 0)
                begin
                    rsp_if.ready <= 1'b0;
                    repeat (g) @(posedge clk);
                end
                rsp_if.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
                || (psel && penable))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int dice;
        int sides;
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        req_if.valid  <= 1'b0;
        req_if.reseed <= 1'b0;
        steady_req    = 1'b0;
        rolled        = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: first roll starts from a zero seed.
        send_req(1'b0);
        send_req(1'b1);
        send_req(1'b0);
        // Zero dice gives a zero sum and leaves the seed alone.
        set_dice(0, 6, 427);
        send_req(1'b1);
        send_req(1'b0);
        // Most dice with sides beyond the usual range.
        set_dice(15, 127, 427);
        send_req(1'b0);
        send_req(1'b1);
        // Zero sides: every die shows one.
        set_dice(15, 0, 427);
        send_req(1'b0);
        send_req(1'b1);
        // Start seed above the generator modulus.
        set_dice(5, 100, 1023);
        send_req(1'b1);
        send_req(1'b0);
        set_dice(1, 1, 0);
        send_req(1'b1);
        send_req(1'b0);
        // A write to the spare address must change nothing.
        drain();
        apb_write(REG_UNUSED, SEED_W'($urandom_range(0, 1023)));
        send_req(1'b0);
        set_dice(15, 100, 728);
        send_req(1'b1);
        send_req(1'b1);
        send_req(1'b0);
        set_dice(15, 127, 729);
        send_req(1'b1);
        send_req(1'b0);

        phase = 0;
        rolled = 0;
        while (rolled < RANDOM_ITEMS)
        begin
            dice = $urandom_range(99);
            dice = (dice < 10) ? 15 : (dice < 15) ? 0 : $urandom_range(1, 6);
            sides = $urandom_range(99);
            sides = (sides < 10) ? 0 : (sides < 20) ? $urandom_range(101, 127)
                                                    : $urandom_range(1, 100);
            drain();
            if ($urandom_range(3) != 0)
                apb_write(REG_DICE_COUNT, SEED_W'(dice));
            if ($urandom_range(3) != 0)
                apb_write(REG_SIDE_COUNT, SEED_W'(sides));
            apb_write(REG_START_SEED, SEED_W'($urandom_range(0, 1023)));
            steady_req = ($urandom_range(4) == 0);
            if (phase == 2)
            begin
                // Keep offering long rolls while the result side is held off,
                // so the input backs up.
                apb_write(REG_DICE_COUNT, SEED_W'(15));
                steady_req = 1'b1;
            end
            send_random($urandom_range(20, 60), $urandom_range(5, 30));
            phase++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: lcg_dice_sum_roller.f
rtl/lds_pkg.sv
rtl/lds_ifs.sv
rtl/lds_sequencer.sv
rtl/lds_lcg.sv
rtl/lds_divider.sv
rtl/lcg_dice_sum_roller.sv
bench/lds_checker.sv
bench/tb_top.sv
